// ===== design/assert_macros.svh =====
// assertion macros for the checker file
// no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define UDEC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked only while reset is held
`define UDEC_ASSERT_IN_RESET(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) !rstn |-> prop) else $error(msg);

`endif

// ===== design/udec_pkg.sv =====
// shared types, constants and helper functions for the decimal text unit
// no dependencies
`timescale 1ns / 1ps

package udec_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int CHAR_WIDTH      = 6;
    localparam int BITS_PER_STEP   = 4;
    localparam int QUEUE_DEPTH     = 2;

    typedef logic [3:0]            bcd_digit_t;
    typedef logic [CHAR_WIDTH-1:0] ascii_char_t;

    localparam ascii_char_t ASCII_ZERO = 6'd48;

    // decimal digits needed for the largest value of a w-bit word
    function automatic int dec_digits(input int w);
        return (w * 30103) / 100000 + 1;
    endfunction

    // shift steps of BITS_PER_STEP bits each for a w-bit word
    function automatic int step_count(input int w);
        return (w + BITS_PER_STEP - 1) / BITS_PER_STEP;
    endfunction

    // double dabble correction of one bcd digit
    function automatic bcd_digit_t dabble_fix(input bcd_digit_t d);
        bcd_digit_t r;
        r = (d >= 4'd5) ? (d + 4'd3) : d;
        return r;
    endfunction

    function automatic ascii_char_t ascii_of(input bcd_digit_t d);
        ascii_char_t c;
        case (d)
            4'd0:    c = 6'd48;
            4'd1:    c = 6'd49;
            4'd2:    c = 6'd50;
            4'd3:    c = 6'd51;
            4'd4:    c = 6'd52;
            4'd5:    c = 6'd53;
            4'd6:    c = 6'd54;
            4'd7:    c = 6'd55;
            4'd8:    c = 6'd56;
            4'd9:    c = 6'd57;
            default: c = ASCII_ZERO;
        endcase
        return c;
    endfunction

endpackage

// ===== design/udec_if.sv =====
// stream interfaces: binary number words in, ascii digit words out
// depends on udec_pkg
`timescale 1ns / 1ps

interface udec_num_if #(
    parameter int VALUE_WIDTH = udec_pkg::VALUE_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface udec_char_if;
    logic                  valid;
    logic                  ready;
    udec_pkg::ascii_char_t digit_char;
    logic                  last;

    modport source (output valid, output digit_char, output last, input ready);
    modport sink   (input valid, input digit_char, input last, output ready);
endinterface

// ===== design/udec_front.sv =====
// front end: accepts number words, counts the nibbles that matter and
// left-aligns the value for the converter; depends on udec_pkg, udec_if
`timescale 1ns / 1ps

module udec_front #(
    parameter int VALUE_WIDTH = udec_pkg::VALUE_WIDTH_DEF,
    parameter int QW          = 8
) (
    udec_num_if.sink   number,
    input  logic          full,
    output logic          push,
    output logic [QW-1:0] push_data
);
    import udec_pkg::*;

    localparam int NSTEPS = step_count(VALUE_WIDTH);
    localparam int PAD_W  = NSTEPS * BITS_PER_STEP;
    localparam int SCNT_W = $clog2(NSTEPS + 1);

    logic [PAD_W-1:0]  padded;
    logic [PAD_W-1:0]  aligned;
    logic [SCNT_W-1:0] used_steps;
    logic [SCNT_W-1:0] skip_steps;

    assign padded = PAD_W'(number.value);

    // steps up to the top nonzero nibble, at least one so zero still converts
    always_comb
    begin
        used_steps = SCNT_W'(1);
        for (int i = 0; i < NSTEPS; i++)
        begin
            if (padded[i*BITS_PER_STEP +: BITS_PER_STEP] != '0)
            begin
                used_steps = SCNT_W'(i + 1);
            end
        end
    end

    assign skip_steps   = SCNT_W'(NSTEPS) - used_steps;
    assign aligned      = padded << {skip_steps, 2'b00};
    assign number.ready = !full;
    assign push         = number.valid && !full;
    assign push_data    = {used_steps, aligned};

endmodule

// ===== design/udec_queue.sv =====
// short register queue between the front end and the converter
// depends on udec_pkg for the default depth
`timescale 1ns / 1ps

module udec_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = udec_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] head
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entries_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/udec_conv.sv =====
// converter: double dabble, four bits shifted in per cycle, result held
// until the emitter takes it; depends on udec_pkg
`timescale 1ns / 1ps

module udec_conv #(
    parameter int VALUE_WIDTH = udec_pkg::VALUE_WIDTH_DEF,
    parameter int QW          = 8,
    parameter int BCD_W       = 40
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  logic [QW-1:0]    head,
    output logic             pop,
    output logic             done,
    output logic [BCD_W-1:0] bcd,
    input  logic             take
);
    import udec_pkg::*;

    localparam int NSTEPS = step_count(VALUE_WIDTH);
    localparam int PAD_W  = NSTEPS * BITS_PER_STEP;
    localparam int SCNT_W = $clog2(NSTEPS + 1);
    localparam int ND     = BCD_W / 4;

    logic              busy_reg, busy_next;
    logic [SCNT_W-1:0] cnt_reg, cnt_next;
    logic [PAD_W-1:0]  sh_reg, sh_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic [PAD_W-1:0]  dab_sh;
    logic [BCD_W-1:0]  dab_bcd;

    assign pop  = !busy_reg && !empty;
    assign done = busy_reg && (cnt_reg == '0);
    assign bcd  = bcd_reg;

    // one step: four rounds of correct-then-shift
    always_comb
    begin
        dab_bcd = bcd_reg;
        dab_sh  = sh_reg;
        for (int k = 0; k < BITS_PER_STEP; k++)
        begin
            for (int j = 0; j < ND; j++)
            begin
                dab_bcd[j*4 +: 4] = dabble_fix(dab_bcd[j*4 +: 4]);
            end
            dab_bcd = {dab_bcd[BCD_W-2:0], dab_sh[PAD_W-1]};
            dab_sh  = {dab_sh[PAD_W-2:0], 1'b0};
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        bcd_next  = bcd_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            cnt_next  = head[QW-1 -: SCNT_W];
            sh_next   = head[PAD_W-1:0];
            bcd_next  = '0;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            cnt_next = cnt_reg - 1'b1;
            sh_next  = dab_sh;
            bcd_next = dab_bcd;
        end
        else if (done && take)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        bcd_reg <= bcd_next;
    end

endmodule

// ===== design/udec_emit.sv =====
// emitter: drops leading zeros and sends one ascii digit word per cycle while
// the receiver is ready, through an output register; depends on udec_pkg, udec_if
`timescale 1ns / 1ps

module udec_emit #(
    parameter int BCD_W = 40
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             done,
    input  logic [BCD_W-1:0] bcd,
    output logic             take,
    udec_char_if.source      text
);
    import udec_pkg::*;

    localparam int ND    = BCD_W / 4;
    localparam int IDX_W = $clog2(ND);

    logic                   active_reg, active_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [ND-1:0][3:0]     digits_reg, digits_next;
    logic                   out_valid_reg, out_valid_next;
    ascii_char_t            out_char_reg, out_char_next;
    logic                   out_last_reg, out_last_next;
    logic [IDX_W-1:0]       top_idx;
    logic                   advance;

    // most significant nonzero digit, digit zero if the value is zero
    always_comb
    begin
        top_idx = '0;
        for (int j = 0; j < ND; j++)
        begin
            if (bcd[j*4 +: 4] != 4'd0)
            begin
                top_idx = IDX_W'(j);
            end
        end
    end

    assign take    = done && !active_reg;
    assign advance = active_reg && (!out_valid_reg || text.ready);

    always_comb
    begin
        active_next    = active_reg;
        idx_next       = idx_reg;
        digits_next    = digits_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (take)
        begin
            active_next = 1'b1;
            idx_next    = top_idx;
            digits_next = bcd;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_char_next  = ascii_of(digits_reg[idx_reg]);
            out_last_next  = (idx_reg == '0);
            if (idx_reg == '0)
            begin
                active_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg - 1'b1;
            end
        end
        else if (out_valid_reg && text.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        digits_reg   <= digits_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign text.valid      = out_valid_reg;
    assign text.digit_char = out_char_reg;
    assign text.last       = out_last_reg;

endmodule

// ===== design/unsigned_to_decimal_ascii_unit.sv =====
// unsigned binary to decimal ascii text, most significant digit first.
// order: the front end queues the number, the converter takes s steps, where
// s = 1..8 is the count of significant nibbles, and the emitter sends the digits.
// throughput: one digit per cycle while the receiver is ready; the converter can
// work on the next number while the single emitter sends the digits of the last.
// reset: async active low, clears queue, converter and output valid.
`timescale 1ns / 1ps

module unsigned_to_decimal_ascii_unit #(
    parameter int VALUE_WIDTH = udec_pkg::VALUE_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    udec_num_if.sink    number,
    udec_char_if.source text
);
    import udec_pkg::*;

    localparam int NSTEPS = step_count(VALUE_WIDTH);
    localparam int PAD_W  = NSTEPS * BITS_PER_STEP;
    localparam int SCNT_W = $clog2(NSTEPS + 1);
    localparam int QW     = SCNT_W + PAD_W;
    localparam int BCD_W  = 4 * dec_digits(VALUE_WIDTH);

    logic             q_full;
    logic             q_push;
    logic [QW-1:0]    q_push_data;
    logic             q_pop;
    logic             q_empty;
    logic [QW-1:0]    q_head;
    logic             conv_done;
    logic [BCD_W-1:0] conv_bcd;
    logic             emit_take;

    udec_front #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .QW          (QW)
    ) u_front (
        .number    (number),
        .full      (q_full),
        .push      (q_push),
        .push_data (q_push_data)
    );

    udec_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    udec_conv #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .QW          (QW),
        .BCD_W       (BCD_W)
    ) u_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .empty (q_empty),
        .head  (q_head),
        .pop   (q_pop),
        .done  (conv_done),
        .bcd   (conv_bcd),
        .take  (emit_take)
    );

    udec_emit #(
        .BCD_W (BCD_W)
    ) u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .done  (conv_done),
        .bcd   (conv_bcd),
        .take  (emit_take),
        .text  (text)
    );

endmodule

// ===== design/udec_checker.sv =====
// port-level checks for the decimal text unit, bound to the top level
// depends on udec_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module udec_checker #(
    parameter int VALUE_WIDTH = udec_pkg::VALUE_WIDTH_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  num_valid,
    input logic                  num_ready,
    input logic                  text_valid,
    input logic                  text_ready,
    input udec_pkg::ascii_char_t digit_char,
    input logic                  last
);
    import udec_pkg::*;

    localparam int ND    = dec_digits(VALUE_WIDTH);
    localparam int RUN_W = $clog2(ND + 1);

    logic [3:0]       pending_reg, pending_next;
    logic [RUN_W-1:0] run_reg, run_next;
    logic             num_acc;
    logic             text_acc;

    assign num_acc  = num_valid && num_ready;
    assign text_acc = text_valid && text_ready;

    // numbers taken whose last digit word has not gone out yet
    always_comb
    begin
        pending_next = pending_reg;
        case ({num_acc, text_acc && last})
            2'b10:   pending_next = pending_reg + 1'b1;
            2'b01:   pending_next = pending_reg - 1'b1;
            default: pending_next = pending_reg;
        endcase
        run_next = run_reg;
        if (text_acc)
        begin
            run_next = last ? '0 : run_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            run_reg     <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            run_reg     <= run_next;
        end
    end

    `UDEC_ASSERT_IN_RESET(a_idle_in_reset, clk, rst_n, !text_valid, "digit word valid in reset")
    `UDEC_ASSERT(a_hold_on_stall, clk, rst_n, text_valid && !text_ready |=> text_valid && $stable(digit_char) && $stable(last), "digit word changed while stalled")
    `UDEC_ASSERT(a_no_orphan_digit, clk, rst_n, text_valid |-> pending_reg != '0, "digit word with no number pending")
    `UDEC_ASSERT(a_no_leading_zero, clk, rst_n, text_valid && run_reg == '0 |-> !(digit_char == ASCII_ZERO && !last), "leading zero emitted")
    `UDEC_ASSERT(a_digit_count, clk, rst_n, text_valid && !last |-> run_reg < RUN_W'(ND - 1), "too many digits in one number")

endmodule

bind unsigned_to_decimal_ascii_unit udec_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_udec_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .num_valid  (number.valid),
    .num_ready  (number.ready),
    .text_valid (text.valid),
    .text_ready (text.ready),
    .digit_char (text.digit_char),
    .last       (text.last)
);

// ===== tb/unsigned_to_decimal_ascii_unit_tb.sv =====
// testbench for the decimal text unit: numbers in, ascii digit words out, checked in order
// depends on udec_pkg, udec_if and unsigned_to_decimal_ascii_unit
`timescale 1ns / 1ps

module unsigned_to_decimal_ascii_unit_tb;

    import udec_pkg::*;

    localparam int VALUE_W     = VALUE_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        ascii_char_t digit_char;
        logic        last;
    } digit_word_t;

    logic clk;
    logic rst_n;

    udec_num_if #(.VALUE_WIDTH(VALUE_W)) num_bus ();
    udec_char_if                         char_bus ();

    unsigned_to_decimal_ascii_unit #(
        .VALUE_WIDTH(VALUE_W)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .number(num_bus),
        .text  (char_bus)
    );

    digit_word_t expected_digits[$];
    int          mismatch_count = 0;
    int          numbers_sent   = 0;
    int          digits_checked = 0;
    int          cycle_count    = 0;
    int          hold_off_left  = 0;
    int          lengths_seen[1:10];
    bit          steady_flow    = 1'b0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d digit words still pending",
                     cycle_count, expected_digits.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic longint unsigned pow10(input int k);
        longint unsigned p;
        p = 1;
        for (int i = 0; i < k; i++)
            p = p * 10;
        return p;
    endfunction

    // digits of the number, most significant first, last flag on the units digit
    function automatic void predict_digits(input logic [VALUE_W-1:0] num);
        logic [VALUE_W-1:0] rem;
        ascii_char_t        rev[$];
        rem = num;
        do
        begin
            rev.push_back(ASCII_ZERO + ascii_char_t'(rem % 10));
            rem = rem / 10;
        end
        while (rem != 0);
        lengths_seen[rev.size()]++;
        for (int k = rev.size() - 1; k >= 0; k--)
            expected_digits.push_back('{digit_char: rev[k], last: (k == 0)});
    endfunction

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // receiver: random ready drops, plus a counted hold-off on request
    initial
    begin
        char_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                char_bus.ready <= 1'b0;
                hold_off_left--;
            end
            else
                char_bus.ready <= steady_flow || ($urandom_range(99) >= 6);
        end
    end

    always @(posedge clk)
    begin : check_digits
        digit_word_t got;
        digit_word_t want;
        if (rst_n && char_bus.valid && char_bus.ready)
        begin
            got = '{digit_char: char_bus.digit_char, last: char_bus.last};
            if (expected_digits.size() == 0)
                note_mismatch($sformatf("unexpected word char=%0d last=%0b",
                                        got.digit_char, got.last));
            else
            begin
                want = expected_digits.pop_front();
                if (got.digit_char !== want.digit_char || got.last !== want.last)
                    note_mismatch($sformatf("expected char=%0d last=%0b, got char=%0d last=%0b",
                                            want.digit_char, want.last,
                                            got.digit_char, got.last));
                digits_checked++;
            end
        end
    end

    // sender: leaves valid high on return so back-to-back words need no extra drive
    task automatic send_number(input logic [VALUE_W-1:0] num);
        while (!steady_flow && $urandom_range(99) < 6)
        begin
            @(negedge clk);
            num_bus.valid <= 1'b0;
        end
        @(negedge clk);
        num_bus.valid <= 1'b1;
        num_bus.value <= num;
        do
            @(posedge clk);
        while (!num_bus.ready);
        predict_digits(num);
        numbers_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        num_bus.valid <= 1'b0;
        while (expected_digits.size() != 0)
            @(posedge clk);
    endtask

    task automatic apply_reset();
        rst_n         = 1'b0;
        num_bus.valid = 1'b0;
        num_bus.value = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    endtask

    task automatic test_directed();
        logic [VALUE_W-1:0] nums[$];
        nums = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd4294967295,
                 32'd4294967294, 32'd1000000000, 32'd999999999, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'd1234567890,
                 VALUE_W'(64'd9876543210), 32'd12345, 32'd100000, 32'd65535,
                 32'd65536, 32'd0, 32'd7};
        foreach (nums[i])
            send_number(nums[i]);
        drain_results();
    endtask

    function automatic logic [VALUE_W-1:0] random_number();
        int      pick;
        int      k;
        longint unsigned lo;
        longint unsigned hi;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            // uniform over digit count, then uniform within that count
            k  = $urandom_range(10, 1);
            lo = (k == 1) ? 0 : pow10(k - 1);
            hi = (k == 10) ? 64'hFFFF_FFFF : pow10(k) - 1;
            return $urandom_range(hi[31:0], lo[31:0]);
        end
        else if (pick < 70)
            return $urandom;
        else if (pick < 85)
            return $urandom_range(20);
        else if (pick < 95)
        begin
            k  = $urandom_range(9, 1);
            lo = pow10(k) - 1 + $urandom_range(2);
            return lo[VALUE_W-1:0];
        end
        else
            return 32'hFFFF_FFFF - $urandom_range(3);
    endfunction

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            steady_flow = (i < 60);
            send_number(random_number());
        end
        steady_flow = 1'b0;
        drain_results();
    endtask

    // output held off long enough for the input side to stall
    task automatic test_backpressure();
        hold_off_left = 300;
        for (int i = 0; i < 12; i++)
            send_number($urandom);
        drain_results();
    endtask

    // sender goes quiet until everything is out, then resumes
    task automatic test_drain_pause(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 12 == 6)
                drain_results();
            send_number(random_number());
        end
        drain_results();
    endtask

    initial
    begin
        int lengths_hit;
        foreach (lengths_seen[i])
            lengths_seen[i] = 0;
        apply_reset();
        test_directed();
        test_random(200);
        test_backpressure();
        test_drain_pause(36);
        repeat (20) @(posedge clk);
        while (expected_digits.size() != 0)
        begin
            digit_word_t left;
            left = expected_digits.pop_front();
            note_mismatch($sformatf("missing word char=%0d last=%0b",
                                    left.digit_char, left.last));
        end
        lengths_hit = 0;
        foreach (lengths_seen[i])
            if (lengths_seen[i] > 0)
                lengths_hit++;
        $display("converted %0d numbers into %0d digit words, %0d of 10 digit lengths seen",
                 numbers_sent, digits_checked, lengths_hit);
        $display("included output hold-off, idle-free stretch and drain pauses, %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/udec_pkg.sv
design/udec_if.sv
design/udec_front.sv
design/udec_queue.sv
design/udec_conv.sv
design/udec_emit.sv
design/unsigned_to_decimal_ascii_unit.sv
design/udec_checker.sv
tb/unsigned_to_decimal_ascii_unit_tb.sv
